FILE: sv/pstn_pkg.sv
// shared types and constants of the tune sequencer
package pstn_pkg;
    typedef struct packed {
        logic [7:0] char_code;
        logic       tune_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [6:0]  note_number;
        logic [23:0] duration_us;
        logic        replay;
        logic        last;
    } t_out;

    localparam logic [1:0] EV_TONE    = 2'd0;
    localparam logic [1:0] EV_SILENCE = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    localparam logic [1:0] ART_NORMAL   = 2'd0;
    localparam logic [1:0] ART_LEGATO   = 2'd1;
    localparam logic [1:0] ART_STACCATO = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MODE = 3'd1;
    localparam logic [2:0] PH_ACC  = 3'd2;
    localparam logic [2:0] PH_NUM  = 3'd3;
    localparam logic [2:0] PH_DOTS = 3'd4;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_L    = 3'd1;
    localparam logic [2:0] CMD_O    = 3'd2;
    localparam logic [2:0] CMD_T    = 3'd3;
    localparam logic [2:0] CMD_P    = 3'd4;
    localparam logic [2:0] CMD_N    = 3'd5;
    localparam logic [2:0] CMD_NOTE = 3'd6;

    localparam logic [31:0] WHOLE_US  = 32'd240000000;
    localparam logic [6:0]  TOP_NOTE  = 7'd84;
    localparam logic [7:0]  TEMPO_DEF = 8'd120;
    localparam logic [15:0] NUM_SAT   = 16'hFFFF;
    localparam logic [4:0]  DOT_SAT   = 5'd31;

    function automatic logic [3:0] letter_step(input logic [2:0] idx);
        logic [3:0] s;
        begin
            unique case (idx)
                3'd0: s = 4'd9;
                3'd1: s = 4'd11;
                3'd2: s = 4'd0;
                3'd3: s = 4'd2;
                3'd4: s = 4'd4;
                3'd5: s = 4'd5;
                3'd6: s = 4'd7;
                default: s = 4'd0;
            endcase
            return s;
        end
    endfunction
endpackage

FILE: sv/pstn_if.sv
// valid/ready channel carrying one payload
interface pstn_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/play_string_tune_sequencer.sv
// tune sequencer top level: character parser and event generator
// One tune character is taken per transfer on i_in; the block then drops
// ready until every event the character causes has been transferred on
// o_out. A character that completes a note or rest runs the shared 32-bit
// restoring divider twice (whole note / tempo, then / length), then walks
// the dots one per cycle (up to 31); up to three events then go to the sink.
// Divisions by 2, 4 and 8 are shifts. Payload bit layout follows t_in and
// t_out of the package.
module play_string_tune_sequencer (
    input  logic i_clk,
    input  logic i_rst_n,
    pstn_if.sink   i_in,
    pstn_if.source o_out
);
    import pstn_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PARSE = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_DOTS = 4'd4;
    localparam logic [3:0] S_EMIT = 4'd5;
    localparam logic [3:0] S_START = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;

    t_in w_in;
    assign w_in = t_in'(i_in.data);

    // player and parse state
    logic [3:0]  r_st, n_st;
    logic [7:0]  r_tempo, n_tempo;
    logic [15:0] r_dlen, n_dlen;
    logic [1:0]  r_art, n_art;
    logic [2:0]  r_oct, n_oct;
    logic        r_rep, n_rep;
    logic [2:0]  r_ph, n_ph;
    logic [2:0]  r_cmd, n_cmd;
    logic [6:0]  r_pnote, n_pnote;
    logic [15:0] r_acc, n_acc;
    logic [4:0]  r_dots, n_dots;
    logic [23:0] r_gap, n_gap;
    logic        r_stop, n_stop;
    logic [7:0]  r_c, n_c;
    // note job: rest or tone, with its length and note
    logic        r_rest, n_rest;
    logic [6:0]  r_jnote, n_jnote;
    logic [15:0] r_jlen, n_jlen;
    logic [4:0]  r_dcnt, n_dcnt;
    // shared divider
    logic [31:0] r_q, n_q;
    logic [32:0] r_rm, n_rm;
    logic [31:0] r_dv, n_dv;
    logic [5:0]  r_it, n_it;
    logic [31:0] r_p, n_p;
    logic [31:0] r_ext, n_ext;
    // event queue, up to three
    t_out        r_ev [3];
    t_out        n_ev [3];
    logic [1:0]  r_ecnt, n_ecnt;
    logic [1:0]  r_eptr, n_eptr;

    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_DRAIN);
    assign o_out.data  = r_ev[r_eptr];

    logic [32:0] w_sub;
    assign w_sub = {r_rm[31:0], r_q[31]} - {1'b0, r_dv};

    always_comb begin
        logic [7:0]  c;
        logic        dig;
        logic [3:0]  dv;
        logic        go_start;
        logic        go_finish;
        logic [19:0] v;
        logic [31:0] s;
        t_out        e;
        n_st = r_st; n_tempo = r_tempo; n_dlen = r_dlen; n_art = r_art;
        n_oct = r_oct; n_rep = r_rep; n_ph = r_ph; n_cmd = r_cmd;
        n_pnote = r_pnote; n_acc = r_acc; n_dots = r_dots; n_gap = r_gap;
        n_stop = r_stop; n_c = r_c; n_rest = r_rest; n_jnote = r_jnote;
        n_jlen = r_jlen; n_dcnt = r_dcnt; n_q = r_q; n_rm = r_rm; n_dv = r_dv;
        n_it = r_it; n_p = r_p; n_ext = r_ext; n_ev = r_ev;
        n_ecnt = r_ecnt; n_eptr = r_eptr;
        c = r_c;
        dig = (c >= 8'h30) && (c <= 8'h39);
        dv = c[3:0];
        go_start = 1'b0; go_finish = 1'b0;
        v = 20'd0; s = 32'd0;
        e = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_ecnt = 2'd0; n_eptr = 2'd0;
                    if (w_in.tune_start) begin
                        n_tempo = TEMPO_DEF; n_dlen = 16'd4; n_art = ART_NORMAL;
                        n_oct = 3'd4; n_rep = 1'b0; n_ph = PH_IDLE;
                        n_cmd = CMD_NONE; n_pnote = 7'd0; n_acc = 16'd0;
                        n_dots = 5'd0; n_gap = 24'd0; n_stop = 1'b0;
                    end
                    // fold lower case onto upper case
                    n_c = (w_in.char_code >= 8'h61 && w_in.char_code <= 8'h7A)
                        ? w_in.char_code - 8'd32 : w_in.char_code;
                    if ((r_stop && !w_in.tune_start) || w_in.char_code == 8'd32
                        || (w_in.char_code >= 8'd9 && w_in.char_code <= 8'd13))
                        n_st = S_IDLE;
                    else
                        n_st = S_PARSE;
                end
            end
            S_PARSE: begin
                n_st = S_DRAIN;
                unique case (r_ph)
                    PH_MODE: begin
                        n_ph = PH_IDLE;
                        if (c == "N") n_art = ART_NORMAL;
                        else if (c == "L") n_art = ART_LEGATO;
                        else if (c == "S") n_art = ART_STACCATO;
                        else if (c == "F") n_rep = 1'b0;
                        else if (c == "B") n_rep = 1'b1;
                        else begin
                            e.event_kind = EV_ERROR;
                            n_ev[0] = e; n_ecnt = 2'd1;
                            n_rep = 1'b0; n_stop = 1'b1; n_ph = PH_IDLE;
                            n_cmd = CMD_NONE; n_acc = 16'd0; n_dots = 5'd0;
                        end
                    end
                    PH_ACC: begin
                        if (c == "#" || c == "+") begin
                            if (r_pnote < TOP_NOTE) n_pnote = r_pnote + 7'd1;
                            n_ph = PH_NUM;
                        end else if (c == "-") begin
                            if (r_pnote > 7'd1) n_pnote = r_pnote - 7'd1;
                            n_ph = PH_NUM;
                        end else if (dig) begin
                            n_acc = {12'd0, dv}; n_ph = PH_NUM;
                        end else if (c == ".") begin
                            n_dots = 5'd1; n_ph = PH_DOTS;
                        end else go_finish = 1'b1;
                    end
                    PH_NUM: begin
                        if (dig) begin
                            v = {r_acc, 3'd0} + {2'd0, r_acc, 1'b0} + {16'd0, dv};
                            n_acc = (v > {4'd0, NUM_SAT}) ? NUM_SAT : v[15:0];
                        end else if (r_cmd == CMD_N && r_acc > {9'd0, TOP_NOTE}) begin
                            e.event_kind = EV_ERROR;
                            n_ev[0] = e; n_ecnt = 2'd1;
                            n_rep = 1'b0; n_stop = 1'b1; n_ph = PH_IDLE;
                            n_cmd = CMD_NONE; n_acc = 16'd0; n_dots = 5'd0;
                        end else begin
                            if (r_cmd == CMD_N) n_pnote = r_acc[6:0];
                            if (c == "." && (r_cmd == CMD_P || r_cmd == CMD_N
                                             || r_cmd == CMD_NOTE)) begin
                                n_dots = 5'd1; n_ph = PH_DOTS;
                            end else go_finish = 1'b1;
                        end
                    end
                    PH_DOTS: begin
                        if (c == ".") begin
                            if (r_dots < DOT_SAT) n_dots = r_dots + 5'd1;
                        end else go_finish = 1'b1;
                    end
                    default: begin
                        n_ph = PH_IDLE;
                        go_start = 1'b1;
                    end
                endcase
                if (go_finish) begin
                    // complete the pending item, the character then starts anew
                    n_st = S_START;
                    n_ph = PH_IDLE; n_cmd = CMD_NONE; n_acc = 16'd0;
                    unique case (r_cmd)
                        CMD_L: begin
                            if (r_acc == 16'd0) begin
                                e.event_kind = EV_ERROR;
                                n_ev[0] = e; n_ecnt = 2'd1;
                                n_rep = 1'b0; n_stop = 1'b1; n_dots = 5'd0;
                                n_st = S_DRAIN;
                            end else n_dlen = r_acc;
                        end
                        CMD_O: n_oct = (r_acc > 16'd6) ? 3'd6 : r_acc[2:0];
                        CMD_T: begin
                            if (r_acc < 16'd32 || r_acc > 16'd255) begin
                                e.event_kind = EV_ERROR;
                                n_ev[0] = e; n_ecnt = 2'd1;
                                n_rep = 1'b0; n_stop = 1'b1; n_dots = 5'd0;
                                n_st = S_DRAIN;
                            end else n_tempo = r_acc[7:0];
                        end
                        CMD_P, CMD_N, CMD_NOTE: begin
                            n_rest = (r_cmd == CMD_P)
                                || (r_cmd == CMD_N && n_pnote == 7'd0);
                            n_jnote = n_pnote;
                            n_jlen = (r_cmd == CMD_P) ? r_acc
                                : (r_cmd == CMD_N || r_acc == 16'd0) ? r_dlen : r_acc;
                            n_dcnt = n_dots;
                            n_q = WHOLE_US; n_rm = 33'd0;
                            n_dv = {24'd0, (r_tempo == 8'd0) ? 8'd1 : r_tempo};
                            n_it = 6'd0;
                            n_st = S_DIV1;
                        end
                        default: ;
                    endcase
                    n_dots = (n_st == S_DIV1) ? n_dots : 5'd0;
                end
            end
            S_DIV1, S_DIV2: begin
                // one quotient bit per cycle
                if (r_it == 6'd32) begin
                    if (r_st == S_DIV1) begin
                        n_q = r_q; n_rm = 33'd0;
                        n_dv = {16'd0, (r_jlen == 16'd0) ? 16'd1 : r_jlen};
                        n_it = 6'd0; n_st = S_DIV2;
                    end else begin
                        if (r_rest) s = 32'd0;
                        else if (r_art == ART_NORMAL) s = r_q >> 3;
                        else if (r_art == ART_STACCATO) s = r_q >> 2;
                        else s = 32'd0;
                        n_p = r_q - s;
                        n_ext = (r_q - s) >> 1;
                        n_rm = {1'b0, s};
                        if (!r_rest) n_gap = s[23:0];
                        n_st = S_DOTS;
                    end
                end else begin
                    n_it = r_it + 6'd1;
                    if (!w_sub[32]) begin
                        n_rm = w_sub;
                        n_q = {r_q[30:0], 1'b1};
                    end else begin
                        n_rm = {r_rm[31:0], r_q[31]};
                        n_q = {r_q[30:0], 1'b0};
                    end
                end
            end
            S_DOTS: begin
                if (r_dcnt != 5'd0) begin
                    n_p = r_p + r_ext; n_ext = r_ext >> 1;
                    n_dcnt = r_dcnt - 5'd1;
                end else begin
                    e.event_kind = r_rest ? EV_SILENCE : EV_TONE;
                    e.note_number = r_rest ? 7'd0 : r_jnote;
                    e.duration_us = r_p[23:0];
                    n_ev[0] = e; n_ecnt = 2'd1;
                    if (r_rm[31:0] != 32'd0) begin
                        e = '0;
                        e.event_kind = EV_SILENCE;
                        e.duration_us = r_rm[23:0];
                        n_ev[1] = e; n_ecnt = 2'd2;
                    end
                    n_dots = 5'd0;
                    n_st = r_stop ? S_DRAIN : S_EMIT;
                end
            end
            S_START: begin
                go_start = 1'b1;
                n_st = S_DRAIN;
            end
            default: ;
        endcase
        if (r_st == S_EMIT) n_st = S_START;
        if (go_start) begin
            n_st = S_DRAIN;
            e = '0;
            unique case (c)
                8'd0: begin
                    e.event_kind = EV_END; e.replay = r_rep;
                    n_ev[n_ecnt] = e; n_ecnt = n_ecnt + 2'd1;
                    if (r_rep) begin
                        n_tempo = TEMPO_DEF; n_dlen = 16'd4; n_art = ART_NORMAL;
                        n_oct = 3'd4; n_rep = 1'b0; n_pnote = 7'd0; n_gap = 24'd0;
                    end else n_stop = 1'b1;
                    n_ph = PH_IDLE; n_cmd = CMD_NONE; n_acc = 16'd0; n_dots = 5'd0;
                end
                "L": begin n_cmd = CMD_L; n_ph = PH_NUM; n_acc = 16'd0; end
                "O": begin n_cmd = CMD_O; n_ph = PH_NUM; n_acc = 16'd0; end
                "T": begin n_cmd = CMD_T; n_ph = PH_NUM; n_acc = 16'd0; end
                "P": begin
                    n_cmd = CMD_P; n_ph = PH_NUM; n_acc = 16'd0; n_dots = 5'd0;
                end
                "N": begin
                    n_cmd = CMD_N; n_ph = PH_NUM; n_acc = 16'd0; n_dots = 5'd0;
                end
                "<": if (n_oct > 3'd0) n_oct = n_oct - 3'd1;
                ">": if (n_oct < 3'd6) n_oct = n_oct + 3'd1;
                "M": n_ph = PH_MODE;
                "A", "B", "C", "D", "E", "F", "G": begin
                    n_pnote = 7'({3'd0, letter_step(3'(c - 8'h41))})
                        + 7'({n_oct, 3'd0}) + 7'({n_oct, 2'd0}) + 7'd1;
                    n_cmd = CMD_NOTE; n_ph = PH_ACC; n_acc = 16'd0; n_dots = 5'd0;
                end
                default: begin
                    e.event_kind = EV_ERROR;
                    n_ev[n_ecnt] = e; n_ecnt = n_ecnt + 2'd1;
                    n_rep = 1'b0; n_stop = 1'b1; n_ph = PH_IDLE;
                    n_cmd = CMD_NONE; n_acc = 16'd0; n_dots = 5'd0;
                end
            endcase
        end
        if (n_st == S_DRAIN && r_st != S_DRAIN) begin
            n_eptr = 2'd0;
            if (n_ecnt == 2'd0) n_st = S_IDLE;
            else n_ev[n_ecnt - 2'd1].last = 1'b1;
        end
        if (r_st == S_DRAIN && o_out.ready) begin
            if (r_eptr + 2'd1 == r_ecnt) n_st = S_IDLE;
            else n_eptr = r_eptr + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_tempo <= TEMPO_DEF; r_dlen <= 16'd4;
            r_art <= ART_NORMAL; r_oct <= 3'd4; r_rep <= 1'b0; r_ph <= PH_IDLE;
            r_cmd <= CMD_NONE; r_pnote <= 7'd0; r_acc <= 16'd0; r_dots <= 5'd0;
            r_gap <= 24'd0; r_stop <= 1'b1; r_ecnt <= 2'd0; r_eptr <= 2'd0;
        end else begin
            r_st <= n_st; r_tempo <= n_tempo; r_dlen <= n_dlen; r_art <= n_art;
            r_oct <= n_oct; r_rep <= n_rep; r_ph <= n_ph; r_cmd <= n_cmd;
            r_pnote <= n_pnote; r_acc <= n_acc; r_dots <= n_dots;
            r_gap <= n_gap; r_stop <= n_stop; r_ecnt <= n_ecnt; r_eptr <= n_eptr;
        end
        r_c <= n_c; r_rest <= n_rest; r_jnote <= n_jnote; r_jlen <= n_jlen;
        r_dcnt <= n_dcnt; r_q <= n_q; r_rm <= n_rm; r_dv <= n_dv; r_it <= n_it;
        r_p <= n_p; r_ext <= n_ext; r_ev <= n_ev;
    end
endmodule

FILE: sim/play_string_tune_sequencer_test.sv
// testbench of the tune sequencer: directed tunes, random tunes and a sink stall
module play_string_tune_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pstn_pkg::*;

    // player state mirrored by the scoreboard
    class tune_scoreboard;
        logic [7:0]  tempo;
        logic [15:0] dlen;
        logic [1:0]  artic;
        logic [2:0]  octave;
        logic        rep_flag;
        logic [2:0]  phase;
        logic [2:0]  cmd;
        logic [6:0]  note;
        logic [15:0] accum;
        logic [4:0]  dots;
        logic [23:0] gap;
        logic        halted;
        t_out        pending_events[$];
        t_out        step_events[$];
        int          errors;
        int          checked;

        function void load_defaults();
            tempo = TEMPO_DEF; dlen = 16'd4; artic = ART_NORMAL; octave = 3'd4;
            rep_flag = 1'b0; phase = PH_IDLE; cmd = CMD_NONE; note = '0;
            accum = '0; dots = '0; gap = '0; halted = 1'b0;
        endfunction

        function new();
            load_defaults();
            halted = 1'b1;
            errors = 0;
            checked = 0;
        endfunction

        function void push_event(logic [1:0] k, logic [6:0] n, logic [31:0] d, logic r);
            t_out e;
            e.event_kind = k; e.note_number = n; e.duration_us = d[23:0];
            e.replay = r; e.last = 1'b0;
            if (step_events.size() < 3) step_events.push_back(e);
        endfunction

        function logic [31:0] period_of(logic [31:0] len);
            logic [31:0] t;
            t = (tempo != 0) ? {24'd0, tempo} : 32'd1;
            return (WHOLE_US / t) / ((len != 0) ? len : 32'd1);
        endfunction

        function logic [31:0] dotted(logic [31:0] p);
            logic [31:0] ext;
            ext = p >> 1;
            for (int k = 0; k < dots; k++) begin
                p += ext;
                ext >>= 1;
            end
            return p;
        endfunction

        function void tone(logic [6:0] n, logic [31:0] len);
            logic [31:0] p, s;
            p = period_of(len);
            s = 0;
            if (artic == ART_NORMAL) s = p >> 3;
            else if (artic == ART_STACCATO) s = p >> 2;
            p = dotted(p - s);
            gap = s[23:0];
            push_event(EV_TONE, n, p, 1'b0);
            if (s > 0) push_event(EV_SILENCE, '0, s, 1'b0);
        endfunction

        function void clear_parse();
            phase = PH_IDLE; cmd = CMD_NONE; accum = '0; dots = '0;
        endfunction

        function void raise_error();
            push_event(EV_ERROR, '0, 0, 1'b0);
            rep_flag = 1'b0;
            halted = 1'b1;
            clear_parse();
        endfunction

        function void complete_item();
            logic [15:0] a;
            a = accum;
            case (cmd)
                CMD_L: begin
                    if (a < 1) begin raise_error(); return; end
                    dlen = a;
                end
                CMD_O: octave = (a > 6) ? 3'd6 : a[2:0];
                CMD_T: begin
                    if (a < 32 || a > 255) begin raise_error(); return; end
                    tempo = a[7:0];
                end
                CMD_P: push_event(EV_SILENCE, '0, dotted(period_of({16'd0, a})), 1'b0);
                CMD_N: begin
                    if (note == 0)
                        push_event(EV_SILENCE, '0, dotted(period_of({16'd0, dlen})), 1'b0);
                    else tone(note, {16'd0, dlen});
                end
                CMD_NOTE: tone(note, (a != 0) ? {16'd0, a} : {16'd0, dlen});
                default: ;
            endcase
            clear_parse();
        endfunction

        function void open_command(logic [7:0] c);
            int steps[7];
            steps = '{9, 11, 0, 2, 4, 5, 7};
            case (c)
                8'd0: begin
                    push_event(EV_END, '0, 0, rep_flag);
                    if (rep_flag) load_defaults();
                    else begin halted = 1'b1; clear_parse(); end
                end
                "L": begin cmd = CMD_L; phase = PH_NUM; accum = 0; end
                "O": begin cmd = CMD_O; phase = PH_NUM; accum = 0; end
                "T": begin cmd = CMD_T; phase = PH_NUM; accum = 0; end
                "P": begin cmd = CMD_P; phase = PH_NUM; accum = 0; dots = 0; end
                "N": begin cmd = CMD_N; phase = PH_NUM; accum = 0; dots = 0; end
                "<": if (octave > 0) octave--;
                ">": if (octave < 6) octave++;
                "M": phase = PH_MODE;
                default: begin
                    if (c >= "A" && c <= "G") begin
                        note = 7'(steps[c - "A"] + octave * 12 + 1);
                        cmd = CMD_NOTE; phase = PH_ACC; accum = 0; dots = 0;
                    end else raise_error();
                end
            endcase
        endfunction

        function void complete_then(logic [7:0] c);
            complete_item();
            if (!halted) open_command(c);
        endfunction

        // notes one accepted character and queues what it should produce
        function void note_input(t_in x);
            logic [7:0]  c;
            logic        digit;
            logic [31:0] v;
            step_events.delete();
            c = x.char_code;
            if (x.tune_start) load_defaults();
            if (halted) return;
            if (c == 32 || (c >= 9 && c <= 13)) return;
            if (c >= "a" && c <= "z") c = c - 8'd32;
            digit = (c >= "0" && c <= "9");
            case (phase)
                PH_MODE: begin
                    phase = PH_IDLE;
                    if (c == "N") artic = ART_NORMAL;
                    else if (c == "L") artic = ART_LEGATO;
                    else if (c == "S") artic = ART_STACCATO;
                    else if (c == "F") rep_flag = 1'b0;
                    else if (c == "B") rep_flag = 1'b1;
                    else raise_error();
                end
                PH_ACC: begin
                    if (c == "#" || c == "+") begin
                        if (note < TOP_NOTE) note++;
                        phase = PH_NUM;
                    end else if (c == "-") begin
                        if (note > 1) note--;
                        phase = PH_NUM;
                    end else if (digit) begin
                        accum = 16'(c - "0"); phase = PH_NUM;
                    end else if (c == ".") begin
                        dots = 1; phase = PH_DOTS;
                    end else complete_then(c);
                end
                PH_NUM: begin
                    if (digit) begin
                        v = accum * 10 + (c - "0");
                        accum = (v > NUM_SAT) ? NUM_SAT : v[15:0];
                    end else if (cmd == CMD_N && accum > TOP_NOTE) begin
                        raise_error();
                    end else begin
                        if (cmd == CMD_N) note = accum[6:0];
                        if (c == "." && (cmd == CMD_P || cmd == CMD_N || cmd == CMD_NOTE)) begin
                            dots = 1; phase = PH_DOTS;
                        end else complete_then(c);
                    end
                end
                PH_DOTS: begin
                    if (c == ".") begin
                        if (dots < DOT_SAT) dots++;
                    end else complete_then(c);
                end
                default: begin
                    phase = PH_IDLE;
                    open_command(c);
                end
            endcase
            if (step_events.size() > 0) step_events[$].last = 1'b1;
            foreach (step_events[i]) pending_events.push_back(step_events[i]);
        endfunction

        // compares one transferred event with the oldest expectation
        function void check_event(t_out got);
            t_out w;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            w = pending_events.pop_front();
            checked++;
            if (got.event_kind !== w.event_kind)
                $display("%0t: event_kind expected %0d actual %0d", $time, w.event_kind,
                         got.event_kind);
            if (got.note_number !== w.note_number)
                $display("%0t: note_number expected %0d actual %0d", $time, w.note_number,
                         got.note_number);
            if (got.duration_us !== w.duration_us)
                $display("%0t: duration_us expected %0d actual %0d", $time, w.duration_us,
                         got.duration_us);
            if (got.replay !== w.replay)
                $display("%0t: replay expected %0b actual %0b", $time, w.replay, got.replay);
            if (got.last !== w.last)
                $display("%0t: last expected %0b actual %0b", $time, w.last, got.last);
            if (got !== w) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pstn_if #(.W($bits(t_in)))  in_ch  (i_clk);
    pstn_if #(.W($bits(t_out))) out_ch (i_clk);

    play_string_tune_sequencer i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    tune_scoreboard tune_board;
    int  cycle_count;
    int  chars_sent;
    bit  hold_sink;        // long sink stall requested by the stimulus
    bit  stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // short gaps mostly, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offers one character and waits for its transfer; valid stays up between
    // back-to-back characters
    task automatic send_char(logic [7:0] c, logic start);
        t_in x;
        int  g;
        g = random_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        x.char_code = c;
        x.tune_start = start;
        in_ch.data  <= x;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        tune_board.note_input(x);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, logic start_first);
        for (int i = 0; i < s.len(); i++) send_char(s[i], start_first && i == 0);
    endtask

    // random tune fragment, mostly well formed
    function automatic string random_token();
        string letters, t;
        int    r;
        letters = "ABCDEFGabcdefg";
        r = $urandom_range(0, 99);
        if (r < 40) begin
            t = string'(letters[$urandom_range(0, 13)]);
            case ($urandom_range(0, 3))
                0: t = {t, "#"};
                1: t = {t, "-"};
                2: t = {t, "+"};
                default: ;
            endcase
            if ($urandom_range(0, 1)) t = {t, $sformatf("%0d", $urandom_range(1, 64))};
            repeat ($urandom_range(0, 2)) t = {t, "."};
        end else if (r < 50) t = $sformatf("L%0d", $urandom_range(0, 64));
        else if (r < 58) t = $sformatf("O%0d", $urandom_range(0, 9));
        else if (r < 66) t = $sformatf("T%0d", $urandom_range(20, 260));
        else if (r < 72) t = $sformatf("P%0d.", $urandom_range(0, 32));
        else if (r < 78) t = $sformatf("N%0d", $urandom_range(0, 90));
        else if (r < 86) begin
            case ($urandom_range(0, 5))
                0: t = "MN"; 1: t = "ML"; 2: t = "MS"; 3: t = "MF"; 4: t = "MB";
                default: t = "MX";
            endcase
        end else if (r < 91) t = $urandom_range(0, 1) ? "<" : ">";
        else if (r < 95) t = " ";
        else t = string'(8'($urandom_range(1, 255)));
        return t;
    endfunction

    // sink side: random ready with gaps, long hold on request
    initial begin
        t_out got;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) out_ch.ready <= 1'b0;
            else out_ch.ready <= (random_gap() == 0) || ($urandom_range(0, 3) == 0);
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                tune_board.check_event(got);
            end
        end
    end

    // long stall of the sink while characters keep coming
    initial begin
        hold_sink = 1'b0;
        wait (chars_sent == 40);
        hold_sink = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[play_string_tune_sequencer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        string s;
        int    wait_cycles;
        tune_board = new();
        chars_sent = 0;
        stimulus_done = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // stopped block ignores characters, then directed tunes
        send_text("C", 1'b0);
        send_text("t255l1c.d#8 e-8MLf MSg+ <<<<<", 1'b1);
        send_text("b- >>>>>>>c#O9N84N0P0.L65535a o0c-", 1'b0);
        send_char(8'd0, 1'b0);
        send_text("MBN85", 1'b1);
        send_text("t32L0", 1'b1);
        send_text("T31", 1'b1);
        send_text("MB\tP1....................................", 1'b1);
        send_text("  ", 1'b0);
        send_char(8'd0, 1'b0);
        send_text("l99999mq", 1'b0);
        send_text("M", 1'b1);
        send_char(8'd0, 1'b0);
        send_text("mf!", 1'b1);

        // random tunes
        while (chars_sent < 307) begin
            send_text(random_token(), 1'b0);
            if ($urandom_range(0, 29) == 0) send_char(8'd0, 1'b0);
            if (tune_board.halted) send_text(random_token(), 1'b1);
        end
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b1);
        send_char(8'd0, 1'b1);
        in_ch.valid <= 1'b0;
        stimulus_done = 1'b1;

        while (tune_board.pending_events.size() > 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 300) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        $display("%0d characters transferred, %0d events checked, including a long sink stall",
                 chars_sent, tune_board.checked);
        if (tune_board.errors == 0 && tune_board.pending_events.size() == 0)
            $display("[play_string_tune_sequencer] OK");
        else
            $display("[play_string_tune_sequencer] ERROR");
        $finish;
    end
endmodule
